### rtl/iee_pkg.sv
package iee_pkg;

  // ASCII codes the evaluator reacts to
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQUAL = 8'h3D;

  // radix of the number reader
  localparam int unsigned RADIX = 10;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL   = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_FIX   = 6'b001000,
    ST_CLOSE = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  // what the operator does once the pending factor is folded in
  typedef enum logic [1:0] {
    CLS_FACTOR = 2'd0,   // '*' or '/'
    CLS_TERM   = 2'd1,   // '+' or '-'
    CLS_EQ     = 2'd2    // '='
  } op_cls_t;

endpackage

### rtl/infix_expression_evaluator_unit.sv
// Infix expression evaluator: + - * / over unsigned decimal literals, ends on '='.
//
// Input channel (in_valid/in_ready/in_char_code): one ASCII character per item.
// Digits build the current number, * and / fold it into the running term,
// + and - close the term into the sum, '=' closes everything and emits one
// result item. Spaces and any unknown character are dropped.
// Output channel (out_valid/out_ready): out_result_value holds the low 32 bits
// of the value; out_div_by_zero is set if any division had a zero divisor
// (that quotient is taken as 0).
// Timing: digits and ignored characters are taken without leaving the idle state.
// An operator with no pending product goes through the close state only. A pending
// '*' or '/' runs the shared adder one bit per cycle: the multiply state for a
// multiply, the divide and sign-fix states for a divide. '=' then passes the done
// state to reach the output register. in_ready is low while an operator is being worked.
// Reset (rst_n, synchronous): clears the expression state and drops any
// pending result. If the receiver stalls, a finished result waits in the
// output register and the block keeps taking characters; a second '=' holds
// in the done state until the first result has been taken.
module infix_expression_evaluator_unit
  import iee_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_char_code,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_result_value,
  output logic               out_div_by_zero
);

  localparam int unsigned W     = VALUE_WIDTH;
  localparam int unsigned AW    = VALUE_WIDTH + 2;      // adder width, room for borrow
  localparam int unsigned CNT_W = $clog2(VALUE_WIDTH);

  // architectural state
  state_t          state_r, state_nxt;
  logic [W-1:0]    num_r, num_nxt;
  logic [W-1:0]    term_r, term_nxt;
  logic [W-1:0]    sum_r, sum_nxt;
  logic            term_is_div_r, term_is_div_nxt;
  logic            term_started_r, term_started_nxt;
  logic            sum_is_sub_r, sum_is_sub_nxt;
  logic            zdiv_r, zdiv_nxt;

  // pending operator
  op_cls_t         cls_r, cls_nxt;
  logic            flag_r, flag_nxt;      // new term_is_div / sum_is_sub

  // iteration registers: a = multiplicand / dividend-quotient,
  // b = multiplier / divisor, c = product / remainder
  logic [W-1:0]    a_r, a_nxt;
  logic [W-1:0]    b_r, b_nxt;
  logic [W-1:0]    c_r, c_nxt;
  logic            neg_r, neg_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // output register
  logic            out_valid_r, out_valid_nxt;
  logic [31:0]     out_value_r, out_value_nxt;
  logic            out_dz_r, out_dz_nxt;

  // shared adder/subtractor
  logic [AW-1:0]   add_a, add_b, add_res;
  logic            add_sub;

  logic            in_fire;
  logic            is_digit;
  logic            is_op;
  logic [3:0]      digit;
  logic [W-1:0]    num_times_radix;
  logic [W:0]      rem_shift;
  logic            qbit;
  logic [W-1:0]    term_mag;
  logic [W-1:0]    num_mag;
  logic [63:0]     sum_ext;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign is_digit  = (in_char_code >= CH_0) && (in_char_code <= CH_9);
  assign is_op     = (in_char_code == CH_STAR) || (in_char_code == CH_SLASH) ||
                     (in_char_code == CH_PLUS) || (in_char_code == CH_MINUS) ||
                     (in_char_code == CH_EQUAL);
  assign digit     = 4'(in_char_code - CH_0);

  // x*10 = x*8 + x*2, wrapping at W bits
  assign num_times_radix = {num_r[W-4:0], 3'b000} + {num_r[W-2:0], 1'b0};

  assign term_mag = term_r[W-1] ? (~term_r + W'(1)) : term_r;
  assign num_mag  = num_r[W-1]  ? (~num_r  + W'(1)) : num_r;

  // restoring division step: shift next dividend bit into the remainder
  assign rem_shift = {c_r, a_r[W-1]};
  assign qbit      = ~add_res[AW-1];

  // shared adder operand selection
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state_r)
      ST_MUL: begin
        add_a = {2'b00, c_r};
        add_b = {2'b00, a_r};
      end
      ST_DIV: begin
        add_a   = {1'b0, rem_shift};
        add_b   = {2'b00, b_r};
        add_sub = 1'b1;
      end
      ST_FIX: begin
        add_b   = {2'b00, a_r};
        add_sub = 1'b1;
      end
      ST_CLOSE: begin
        add_a   = {2'b00, sum_r};
        add_b   = {2'b00, term_r};
        add_sub = sum_is_sub_r;
      end
      ST_IDLE, ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign add_res = add_a + (add_sub ? ~add_b : add_b) + AW'(add_sub);

  assign sum_ext = 64'(sum_r);

  // sequencer
  always_comb begin
    state_nxt        = state_r;
    num_nxt          = num_r;
    term_nxt         = term_r;
    sum_nxt          = sum_r;
    term_is_div_nxt  = term_is_div_r;
    term_started_nxt = term_started_r;
    sum_is_sub_nxt   = sum_is_sub_r;
    zdiv_nxt         = zdiv_r;
    cls_nxt          = cls_r;
    flag_nxt         = flag_r;
    a_nxt            = a_r;
    b_nxt            = b_r;
    c_nxt            = c_r;
    neg_nxt          = neg_r;
    cnt_nxt          = cnt_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_value_nxt    = out_value_r;
    out_dz_nxt       = out_dz_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (is_digit) begin
            num_nxt = num_times_radix + W'(digit);
          end else if (is_op) begin
            // classify the operator
            priority if (in_char_code == CH_STAR || in_char_code == CH_SLASH) begin
              cls_nxt = CLS_FACTOR;
            end else if (in_char_code == CH_EQUAL) begin
              cls_nxt = CLS_EQ;
            end else begin
              cls_nxt = CLS_TERM;
            end
            flag_nxt = (in_char_code == CH_SLASH) || (in_char_code == CH_MINUS);
            num_nxt  = '0;
            cnt_nxt  = CNT_W'(W - 1);
            // fold the pending number into the term
            if (!term_started_r) begin
              term_nxt  = num_r;
              state_nxt = ST_CLOSE;
            end else if (term_is_div_r) begin
              if (num_r == '0) begin
                zdiv_nxt  = 1'b1;
                term_nxt  = '0;
                state_nxt = ST_CLOSE;
              end else begin
                a_nxt     = term_mag;
                b_nxt     = num_mag;
                c_nxt     = '0;
                neg_nxt   = term_r[W-1] ^ num_r[W-1];
                state_nxt = ST_DIV;
              end
            end else begin
              a_nxt     = term_r;
              b_nxt     = num_r;
              c_nxt     = '0;
              state_nxt = ST_MUL;
            end
          end
          // spaces and other characters: no change
        end
      end

      ST_MUL: begin
        // shift-add, low W bits of the product
        if (b_r[0]) begin
          c_nxt = add_res[W-1:0];
        end
        a_nxt   = {a_r[W-2:0], 1'b0};
        b_nxt   = {1'b0, b_r[W-1:1]};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          term_nxt  = b_r[0] ? add_res[W-1:0] : c_r;
          state_nxt = ST_CLOSE;
        end
      end

      ST_DIV: begin
        c_nxt   = qbit ? add_res[W-1:0] : rem_shift[W-1:0];
        a_nxt   = {a_r[W-2:0], qbit};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_FIX;
        end
      end

      ST_FIX: begin
        // restore the sign of the quotient
        term_nxt  = neg_r ? add_res[W-1:0] : a_r;
        state_nxt = ST_CLOSE;
      end

      ST_CLOSE: begin
        unique case (cls_r)
          CLS_FACTOR: begin
            term_started_nxt = 1'b1;
            term_is_div_nxt  = flag_r;
            state_nxt        = ST_IDLE;
          end
          CLS_TERM: begin
            sum_nxt          = add_res[W-1:0];
            term_nxt         = '0;
            term_started_nxt = 1'b0;
            term_is_div_nxt  = 1'b0;
            sum_is_sub_nxt   = flag_r;
            state_nxt        = ST_IDLE;
          end
          CLS_EQ: begin
            sum_nxt   = add_res[W-1:0];
            state_nxt = ST_DONE;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end

      ST_DONE: begin
        // wait for a free output slot, then clear for the next expression
        if (!out_valid_r || out_ready) begin
          out_valid_nxt    = 1'b1;
          out_value_nxt    = sum_ext[31:0];
          out_dz_nxt       = zdiv_r;
          num_nxt          = '0;
          term_nxt         = '0;
          sum_nxt          = '0;
          term_is_div_nxt  = 1'b0;
          term_started_nxt = 1'b0;
          sum_is_sub_nxt   = 1'b0;
          zdiv_nxt         = 1'b0;
          state_nxt        = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      num_r          <= '0;
      term_r         <= '0;
      sum_r          <= '0;
      term_is_div_r  <= 1'b0;
      term_started_r <= 1'b0;
      sum_is_sub_r   <= 1'b0;
      zdiv_r         <= 1'b0;
      cls_r          <= CLS_FACTOR;
      flag_r         <= 1'b0;
      cnt_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      num_r          <= num_nxt;
      term_r         <= term_nxt;
      sum_r          <= sum_nxt;
      term_is_div_r  <= term_is_div_nxt;
      term_started_r <= term_started_nxt;
      sum_is_sub_r   <= sum_is_sub_nxt;
      zdiv_r         <= zdiv_nxt;
      cls_r          <= cls_nxt;
      flag_r         <= flag_nxt;
      cnt_r          <= cnt_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    c_r         <= c_nxt;
    neg_r       <= neg_nxt;
    out_value_r <= out_value_nxt;
    out_dz_r    <= out_dz_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_div_by_zero  = out_dz_r;

  // remainder always stays below the divisor
  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (c_r < b_r))
    else $error("division remainder not below divisor");

  // a bit-serial pass always starts with a full count
  a_iter_start: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_MUL || state_r == ST_DIV) && $past(state_r) == ST_IDLE)
      |-> (cnt_r == CNT_W'(W - 1)))
    else $error("iteration started with wrong count");

  // divide by a zero divisor marks the expression
  a_zero_div_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_op && term_started_r && term_is_div_r && num_r == '0)
      |=> (zdiv_r && term_r == '0))
    else $error("zero divisor not flagged");

  // emitting a result leaves a clean expression state
  a_clear_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && (!out_valid_r || out_ready))
      |=> (out_valid_r && sum_r == '0 && !zdiv_r && !term_started_r && state_r == ST_IDLE))
    else $error("state not cleared after result");

endmodule
